FILE: design/hsg_pkg.sv
// ----------------------------------------------------------------------------
// hsg_pkg
// Shared constants, types and the grey quantizer for the half-size grey
// downsampler.
// ----------------------------------------------------------------------------
package hsg_pkg;

	// default geometry
	localparam int LINE_DEPTH_DEF   = 4096;
	localparam int CELLS_ACROSS_DEF = 32;
	localparam int CELLS_DOWN_DEF   = 8;

	// register reset value and register indexes
	localparam logic [7:0] CELL_SIZE_RST = 8'd20;
	localparam int         CFG_IDX_W     = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 1'b1;

	// field widths
	localparam int CHAN_W    = 8;
	localparam int PIX_W     = 10;
	localparam int PAIR_W    = 11;
	localparam int TOTAL_W   = 12;
	localparam int GREY_W    = 3;
	localparam int OUT_X_W   = 12;
	localparam int OUT_Y_W   = 10;

	// white neighbor of an odd-width cell: three channels at 255
	localparam logic [PAIR_W-1:0] WHITE_PIXEL_SUM = 11'd765;

	// floor(total / 12) >= t  is the same as  total >= 12 * t
	localparam int DIVISOR = 12;
	localparam logic [TOTAL_W-1:0] GREY_T1 = TOTAL_W'(DIVISOR * 'h30);
	localparam logic [TOTAL_W-1:0] GREY_T2 = TOTAL_W'(DIVISOR * 'h60);
	localparam logic [TOTAL_W-1:0] GREY_T3 = TOTAL_W'(DIVISOR * 'h90);
	localparam logic [TOTAL_W-1:0] GREY_T4 = TOTAL_W'(DIVISOR * 'hC0);

	localparam logic [GREY_W-1:0] GREY_MAX = 3'd4;

	typedef struct packed {
		logic op;     // item reaches the line store
		logic lower;  // lower row of a block: read and emit
		logic last;   // final result of the image
	} scan_flags_t;

	function automatic logic [GREY_W-1:0] grey_of(input logic [TOTAL_W-1:0] total);
		logic [GREY_W-1:0] g;
		if (total >= GREY_T4) begin
			g = 3'd4;
		end else if (total >= GREY_T3) begin
			g = 3'd3;
		end else if (total >= GREY_T2) begin
			g = 3'd2;
		end else if (total >= GREY_T1) begin
			g = 3'd1;
		end else begin
			g = 3'd0;
		end
		return g;
	endfunction

endpackage

FILE: design/hsg_scan.sv
// ----------------------------------------------------------------------------
// hsg_scan
// Raster position tracking, pixel sums and pairing of horizontal neighbors.
// ----------------------------------------------------------------------------
module hsg_scan #(
	parameter int  CELLS_ACROSS = hsg_pkg::CELLS_ACROSS_DEF,
	parameter int  CELLS_DOWN   = hsg_pkg::CELLS_DOWN_DEF,
	localparam int CCW = (CELLS_ACROSS > 1) ? $clog2(CELLS_ACROSS) : 1,
	localparam int CRW = (CELLS_DOWN > 1) ? $clog2(CELLS_DOWN) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       sof,
	input  logic [7:0]                 red,
	input  logic [7:0]                 green,
	input  logic [7:0]                 blue,
	input  logic [7:0]                 cell_width,
	input  logic [7:0]                 cell_height,
	output hsg_pkg::scan_flags_t       flags,
	output logic [hsg_pkg::PAIR_W-1:0] pair,
	output logic [CCW-1:0]             cell_column,
	output logic [6:0]                 bx,
	output logic [CRW-1:0]             cell_row,
	output logic [6:0]                 by,
	output logic [7:0]                 dw,
	output logic [6:0]                 dh
);
	import hsg_pkg::*;

	logic [7:0]       col_q, row_q;
	logic [CCW-1:0]   cc_q;
	logic [CRW-1:0]   cr_q;
	logic [PIX_W-1:0] left_q;

	logic [7:0]       col, row, cw, ch;
	logic [PIX_W-1:0] pix;
	logic [8:0]       row_inc;
	logic             col_wrap, cc_wrap, row_wrap, cr_wrap;
	logic             active, odd;

	// start of image clears the position before this pixel is used
	assign col         = sof ? 8'd0 : col_q;
	assign row         = sof ? 8'd0 : row_q;
	assign cell_column = sof ? '0 : cc_q;
	assign cell_row    = sof ? '0 : cr_q;

	assign cw = (cell_width == 8'd0) ? 8'd1 : cell_width;
	assign ch = (cell_height == 8'd0) ? 8'd1 : cell_height;

	assign pix     = PIX_W'(red) + PIX_W'(green) + PIX_W'(blue);
	assign row_inc = {1'b0, row} + 9'd1;

	assign col_wrap = ({1'b0, col} + 9'd1) >= {1'b0, cw};
	assign cc_wrap  = ({1'b0, cell_column} + 1'b1) >= (CCW + 1)'(CELLS_ACROSS);
	assign row_wrap = row_inc >= {1'b0, ch};
	assign cr_wrap  = ({1'b0, cell_row} + 1'b1) >= (CRW + 1)'(CELLS_DOWN);

	// the last row of an odd-height cell is dropped
	assign active = row[0] || !row_wrap;
	assign odd    = col[0];

	assign flags.op    = active && (odd || col_wrap);
	assign flags.lower = row[0];
	assign flags.last  = col_wrap && (row_inc >= {1'b0, ch & 8'hFE}) && cc_wrap && cr_wrap;

	assign pair = odd ? (PAIR_W'(left_q) + PAIR_W'(pix)) : (PAIR_W'(pix) + WHITE_PIXEL_SUM);

	assign bx = col[7:1];
	assign by = row[7:1];
	assign dw = 8'(({1'b0, cw} + 9'd1) >> 1);
	assign dh = ch[7:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cc_q   <= '0;
			cr_q   <= '0;
			left_q <= '0;
		end else if (accept) begin
			// hold the left pixel of a pair until its partner arrives
			if (active && !odd && !col_wrap) begin
				left_q <= pix;
			end
			if (col_wrap) begin
				col_q <= '0;
				if (cc_wrap) begin
					cc_q <= '0;
					if (row_wrap) begin
						row_q <= '0;
						cr_q  <= cr_wrap ? '0 : cell_row + 1'b1;
					end else begin
						row_q <= row + 8'd1;
						cr_q  <= cell_row;
					end
				end else begin
					cc_q  <= cell_column + 1'b1;
					row_q <= row;
					cr_q  <= cell_row;
				end
			end else begin
				col_q <= col + 8'd1;
				cc_q  <= cell_column;
				row_q <= row;
				cr_q  <= cell_row;
			end
		end
	end

endmodule

FILE: design/hsg_line_store.sv
// ----------------------------------------------------------------------------
// hsg_line_store
// Single-port line memory for the upper-row pair sums, registered read.
// ----------------------------------------------------------------------------
module hsg_line_store #(
	parameter int  DEPTH = hsg_pkg::LINE_DEPTH_DEF,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic                       rd_en,
	input  logic [AW-1:0]              addr,
	input  logic [hsg_pkg::PAIR_W-1:0] wr_data,
	output logic [hsg_pkg::PAIR_W-1:0] rd_data
);
	import hsg_pkg::*;

	logic [PAIR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[addr];
		end
	end

	// an item is either an upper-row write or a lower-row read
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n) !(wr_en && rd_en))
		else $error("line store written and read in the same cycle");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en || rd_en) |-> (32'(addr) < DEPTH))
		else $error("line store address beyond depth");

endmodule

FILE: design/half_size_grey_downsampler.sv
// ----------------------------------------------------------------------------
// half_size_grey_downsampler
// 2x2 box downsampler of a glyph-cell grid to five grey levels.
// ----------------------------------------------------------------------------
// Usage:
//   Source pixels enter on the s_axis channel in raster order, tuser high on
//   the first pixel of an image. A 2x2 block of a cell yields one result on
//   m_axis when its lower-right pixel arrives; tlast marks the final result.
//   cell_width / cell_height are written over the cfg port while idle.
// Throughput: one pixel per clock while the receiver keeps up.
// Pipeline: after the accepting edge, the destination multiply, the
//   reciprocal multiply of the line index, the subtract and the line memory
//   read, and the output register are each registered in turn.
// Stalls: each stage only holds while the stage after it is full, so input
//   is still taken while a result waits; s_axis_tready falls only when all
//   four internal stages and the output register are occupied.
// Reset: position counters, the left-pixel sum and stage valids clear, cell
//   size registers return to 20; the line memory is not cleared, since every
//   lower-row read follows an upper-row write of the same entry.
// ----------------------------------------------------------------------------
module half_size_grey_downsampler #(
	parameter int LINE_DEPTH   = hsg_pkg::LINE_DEPTH_DEF,
	parameter int CELLS_ACROSS = hsg_pkg::CELLS_ACROSS_DEF,
	parameter int CELLS_DOWN   = hsg_pkg::CELLS_DOWN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [hsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,  // red, green, blue
	input  logic                          s_axis_tuser,  // start_of_image
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [31:0]                   m_axis_tdata,  // grey_level, out_x, out_y
	output logic                          m_axis_tlast   // last
);
	import hsg_pkg::*;

	localparam int CCW   = (CELLS_ACROSS > 1) ? $clog2(CELLS_ACROSS) : 1;
	localparam int CRW   = (CELLS_DOWN > 1) ? $clog2(CELLS_DOWN) : 1;
	localparam int XW    = $clog2(CELLS_ACROSS * 128);
	localparam int YW    = $clog2(CELLS_DOWN * 128);
	localparam int LDW   = $clog2(LINE_DEPTH);
	localparam int SH    = XW + LDW;
	localparam int RECIP = ((1 << SH) + LINE_DEPTH - 1) / LINE_DEPTH;
	localparam int RW    = $clog2(RECIP + 1);

	// configuration
	logic [7:0] cell_width_q, cell_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= CELL_SIZE_RST;
			cell_height_q <= CELL_SIZE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CELL_WIDTH:  cell_width_q  <= cfg_data;
				REG_CELL_HEIGHT: cell_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end
	logic              accept;
	scan_flags_t       flags;
	logic [PAIR_W-1:0] pair;
	logic [CCW-1:0]    cell_column;
	logic [CRW-1:0]    cell_row;
	logic [6:0]        bx, by, dh;
	logic [7:0]        dw;

	assign accept = s_axis_tvalid && s_axis_tready;

	hsg_scan #(
		.CELLS_ACROSS (CELLS_ACROSS),
		.CELLS_DOWN   (CELLS_DOWN)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sof         (s_axis_tuser),
		.red         (s_axis_tdata[7:0]),
		.green       (s_axis_tdata[15:8]),
		.blue        (s_axis_tdata[23:16]),
		.cell_width  (cell_width_q),
		.cell_height (cell_height_q),
		.flags       (flags),
		.pair        (pair),
		.cell_column (cell_column),
		.bx          (bx),
		.cell_row    (cell_row),
		.by          (by),
		.dw          (dw),
		.dh          (dh)
	);

	// stage valids and flow control
	logic v_s1, v_s2, v_s3, v_s4;
	logic ld_s1, ld_s2, ld_s3, ld_s4, take_s4, out_free;
	logic m_valid_q;

	scan_flags_t       f_s1, f_s2, f_s3, f_s4;
	logic [PAIR_W-1:0] pair_s1, pair_s2, pair_s3, pair_s4;
	logic [CCW-1:0]    cc_s1;
	logic [CRW-1:0]    cr_s1;
	logic [6:0]        bx_s1, by_s1, dh_s1;
	logic [7:0]        dw_s1;
	logic [XW-1:0]     x_s2, x_s3, x_s4;
	logic [YW-1:0]     y_s2, y_s3, y_s4;
	logic [XW-1:0]     q_s3;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign take_s4       = v_s4 && (!f_s4.lower || out_free);
	assign ld_s4         = !v_s4 || take_s4;
	assign ld_s3         = !v_s3 || ld_s4;
	assign ld_s2         = !v_s2 || ld_s3;
	assign ld_s1         = !v_s1 || ld_s2;
	assign s_axis_tready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= accept && flags.op;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
		end
	end

	// s1: capture position of a completed pair
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			f_s1    <= flags;
			pair_s1 <= pair;
			cc_s1   <= cell_column;
			cr_s1   <= cell_row;
			bx_s1   <= bx;
			by_s1   <= by;
			dw_s1   <= dw;
			dh_s1   <= dh;
		end
	end

	// s2: destination coordinates
	logic [XW-1:0] x_full;
	logic [YW-1:0] y_full;

	assign x_full = XW'(cc_s1) * XW'(dw_s1) + XW'(bx_s1);
	assign y_full = YW'(cr_s1) * YW'(dh_s1) + YW'(by_s1);

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			f_s2    <= f_s1;
			pair_s2 <= pair_s1;
			x_s2    <= x_full;
			y_s2    <= y_full;
		end
	end

	// s3: quotient of x by the line depth through a reciprocal multiply
	logic [XW+RW-1:0] q_prod;

	assign q_prod = (XW + RW)'(x_s2) * (XW + RW)'(RECIP);

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			f_s3    <= f_s2;
			pair_s3 <= pair_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			q_s3    <= XW'(q_prod >> SH);
		end
	end

	// s3 -> s4: line index and memory access, both issued on the same hop
	logic [XW+LDW:0]   q_mult;
	logic [LDW-1:0]    slot;
	logic              mem_go;
	logic [PAIR_W-1:0] upper_s4;

	assign q_mult = (XW + LDW + 1)'(q_s3) * (XW + LDW + 1)'(LINE_DEPTH);
	assign slot   = LDW'(x_s3 - XW'(q_mult));
	assign mem_go = v_s3 && ld_s4;

	hsg_line_store #(
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_go && !f_s3.lower),
		.rd_en   (mem_go && f_s3.lower),
		.addr    (slot),
		.wr_data (pair_s3),
		.rd_data (upper_s4)
	);

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			f_s4    <= f_s3;
			pair_s4 <= pair_s3;
			x_s4    <= x_s3;
			y_s4    <= y_s3;
		end
	end

	// s4 -> output: block total and quantize
	logic [TOTAL_W-1:0] total;
	logic [GREY_W-1:0]  grey_q;
	logic [OUT_X_W-1:0] out_x_q;
	logic [OUT_Y_W-1:0] out_y_q;
	logic               last_q;
	logic               emit;

	assign total = TOTAL_W'(upper_s4) + TOTAL_W'(pair_s4);
	assign emit  = take_s4 && f_s4.lower;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			grey_q  <= grey_of(total);
			out_x_q <= OUT_X_W'(x_s4);
			out_y_q <= OUT_Y_W'(y_s4);
			last_q  <= f_s4.last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, out_y_q, out_x_q, grey_q};
	assign m_axis_tlast  = last_q;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && m_valid_q))
		else $error("input stalled with a free stage");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_axis_tvalid)
		else $error("lower-row block lost on the way out");

	a_grey_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] <= GREY_MAX))
		else $error("grey level out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !emit)
		else $error("output register overwritten while stalled");

endmodule
